>>> rtl/tisg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tisg_pkg
// Shared constants, types and GF(251) helpers for the threshold image share
// generator.
// ----------------------------------------------------------------------------
package tisg_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_THRESHOLD_DEF = 8;
  localparam int MAX_SHARES_DEF    = 8;
  localparam int COORD_WIDTH_DEF   = 12;

  // Field widths fixed by the pixel and share formats.
  localparam int CHAN_W      = 8;
  localparam int SHARE_IDX_W = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int CNT_CFG_W   = 4;

  // Lane control fields are sized for the largest parameter values.
  localparam int LANE_ADDR_W = 4;
  localparam int LANE_X_W    = 8;

  localparam logic [8:0]        PRIME     = 9'd251;
  localparam logic [CHAN_W-1:0] CLAMP_TOP = 8'd250;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [CNT_CFG_W-1:0]  THRESHOLD_RST = 4'd2;
  localparam logic [CNT_CFG_W-1:0]  SHARES_RST    = 4'd4;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST     = 13'd512;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST    = 13'd512;

  typedef struct packed {
    logic                   wr_en;
    logic [LANE_ADDR_W-1:0] wr_addr;
    logic                   step;
    logic                   first;
    logic [LANE_ADDR_W-1:0] rd_addr;
    logic [LANE_X_W-1:0]    x;
  } lane_ctl_t;

  typedef struct packed {
    logic                   load;
    logic [SHARE_IDX_W-1:0] index;
    logic                   last;
  } emit_t;

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] v);
    clamp_chan = (v > CLAMP_TOP) ? CLAMP_TOP : v;
  endfunction

  // Reduction modulo 251 using 256 = 5 (mod 251): two folds and one
  // conditional subtract cover every 16-bit input.
  function automatic logic [CHAN_W-1:0] mod_prime(input logic [15:0] v);
    logic [10:0] s1;
    logic [8:0]  s2;
    s1 = {1'b0, v[15:8], 2'b00} + {3'b000, v[15:8]} + {3'b000, v[7:0]};
    s2 = {4'b0000, s1[10:8], 2'b00} + {6'b000000, s1[10:8]} + {1'b0, s1[7:0]};
    if (s2 >= PRIME) begin
      s2 = s2 - PRIME;
    end
    mod_prime = s2[7:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/tisg_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tisg_lane
// One channel lane: coefficient store and a Horner step unit that evaluates
// the channel polynomial modulo 251, one coefficient per cycle in which the step control is set.
// ----------------------------------------------------------------------------
module tisg_lane #(
  parameter int MAX_THRESHOLD = tisg_pkg::MAX_THRESHOLD_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tisg_pkg::lane_ctl_t         ctl_i,
  input  wire logic [tisg_pkg::CHAN_W-1:0] pix_i,
  output logic [tisg_pkg::CHAN_W-1:0]      res_o
);
  import tisg_pkg::*;

  localparam int AW = $clog2(MAX_THRESHOLD);

  logic [CHAN_W-1:0] coef_q [MAX_THRESHOLD];
  logic [CHAN_W-1:0] acc_q;
  logic [CHAN_W-1:0] acc_in;
  logic [15:0]       prod;
  logic [15:0]       sum;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      coef_q[ctl_i.wr_addr[AW-1:0]] <= clamp_chan(pix_i);
    end
  end

  // The first step of each evaluation starts from a zero accumulator.
  assign acc_in = ctl_i.first ? '0 : acc_q;
  assign prod   = acc_in * ctl_i.x;
  assign sum    = prod + {8'h00, coef_q[ctl_i.rd_addr[AW-1:0]]};
  assign res_o  = mod_prime(sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.step) begin
      acc_q <= res_o;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tisg_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tisg_ctrl
// Configuration registers, group collection, shadow position tracking and
// the evaluation sequencer that steps all lanes through Horner's rule.
// ----------------------------------------------------------------------------
module tisg_ctrl #(
  parameter int MAX_THRESHOLD = tisg_pkg::MAX_THRESHOLD_DEF,
  parameter int MAX_SHARES    = tisg_pkg::MAX_SHARES_DEF,
  parameter int COORD_WIDTH   = tisg_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tisg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tisg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            out_free_i,
  output tisg_pkg::lane_ctl_t                  lane_ctl_o,
  output tisg_pkg::emit_t                      emit_o,
  output logic [COORD_WIDTH-1:0]               out_row_o,
  output logic [COORD_WIDTH-1:0]               out_col_o
);
  import tisg_pkg::*;

  localparam int TW   = $clog2(MAX_THRESHOLD);
  localparam int RW   = $clog2(MAX_THRESHOLD + 1);
  localparam int NW   = $clog2(MAX_SHARES + 1);
  localparam int TCW  = (NW > SHARE_IDX_W) ? NW : SHARE_IDX_W;
  localparam int CW   = COORD_WIDTH;
  localparam logic [31:0] SPAN = 32'd1 << CW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic [CNT_CFG_W-1:0]  thr_q, shr_q;
  logic [CFG_DATA_W-1:0] wid_q, hgt_q;

  logic          state_q, state_d;
  logic [TW-1:0] fill_q, fill_d;
  logic [CW:0]   row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [TW-1:0] rm1_q, rm1_d;
  logic [TW-1:0] k_q, k_d;
  logic [TCW-1:0] t_q, t_d;
  logic [TCW-1:0] n_q, n_d;
  logic          first_q, first_d;
  logic [CW-1:0] erow_q, erow_d;
  logic [CW-1:0] ecol_q, ecol_d;

  logic [RW-1:0]  r_eff;
  logic [TCW-1:0] n_eff;
  logic [CW:0]    w_eff, h_eff;
  logic           accept, group_done, in_range, step_en, share_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      shr_q <= SHARES_RST;
      wid_q <= WIDTH_RST;
      hgt_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q <= cfg_data_i[CNT_CFG_W-1:0];
        REG_SHARES:    shr_q <= cfg_data_i[CNT_CFG_W-1:0];
        REG_WIDTH:     wid_q <= cfg_data_i;
        REG_HEIGHT:    hgt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective settings after clamping to the supported ranges.
  always_comb begin
    if (thr_q == '0) begin
      r_eff = RW'(1);
    end else if (32'(thr_q) > 32'(MAX_THRESHOLD)) begin
      r_eff = RW'(MAX_THRESHOLD);
    end else begin
      r_eff = RW'(thr_q);
    end
    n_eff = (32'(shr_q) > 32'(MAX_SHARES)) ? TCW'(MAX_SHARES) : TCW'(shr_q);
    w_eff = (32'(wid_q) > SPAN) ? SPAN[CW:0] : (CW+1)'(wid_q);
    h_eff = (32'(hgt_q) > SPAN) ? SPAN[CW:0] : (CW+1)'(hgt_q);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign group_done = !(32'(fill_q) + 32'd1 < 32'(r_eff));
  assign in_range   = (32'(row_q) < 32'(h_eff)) && (32'(col_q) < 32'(w_eff));
  assign share_done = (k_q == '0);
  // The final Horner step of a share needs a free output register.
  assign step_en    = (state_q == ST_EVAL) && (!share_done || out_free_i);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    row_d   = row_q;
    col_d   = col_q;
    rm1_d   = rm1_q;
    k_d     = k_q;
    t_d     = t_q;
    n_d     = n_q;
    first_d = first_q;
    erow_d  = erow_q;
    ecol_d  = ecol_q;

    if (accept) begin
      if (!group_done) begin
        fill_d = fill_q + TW'(1);
      end else begin
        fill_d = '0;
        if (in_range && (n_eff != '0)) begin
          state_d = ST_EVAL;
          rm1_d   = TW'(r_eff - RW'(1));
          k_d     = TW'(r_eff - RW'(1));
          t_d     = '0;
          n_d     = n_eff;
          first_d = 1'b1;
          erow_d  = row_q[CW-1:0];
          ecol_d  = col_q;
        end
        if (32'(col_q) + 32'd1 >= 32'(w_eff)) begin
          col_d = '0;
          if (32'(row_q) < SPAN) begin
            row_d = row_q + (CW+1)'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end

    if (step_en) begin
      if (!share_done) begin
        k_d     = k_q - TW'(1);
        first_d = 1'b0;
      end else if (t_q + TCW'(1) == n_q) begin
        state_d = ST_IDLE;
      end else begin
        t_d     = t_q + TCW'(1);
        k_d     = rm1_q;
        first_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      rm1_q   <= '0;
      k_q     <= '0;
      t_q     <= '0;
      n_q     <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      row_q   <= row_d;
      col_q   <= col_d;
      rm1_q   <= rm1_d;
      k_q     <= k_d;
      t_q     <= t_d;
      n_q     <= n_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    erow_q <= erow_d;
    ecol_q <= ecol_d;
  end

  always_comb begin
    lane_ctl_o.wr_en   = accept;
    lane_ctl_o.wr_addr = LANE_ADDR_W'(fill_q);
    lane_ctl_o.step    = step_en;
    lane_ctl_o.first   = first_q;
    lane_ctl_o.rd_addr = LANE_ADDR_W'(k_q);
    lane_ctl_o.x       = LANE_X_W'(t_q) + LANE_X_W'(1);
  end

  assign emit_o.load  = step_en && share_done;
  assign emit_o.index = t_q[SHARE_IDX_W-1:0];
  assign emit_o.last  = (t_q + TCW'(1) == n_q);
  assign out_row_o    = erow_q;
  assign out_col_o    = ecol_q;

endmodule
`default_nettype wire

>>> rtl/threshold_image_share_generator.sv
`default_nettype none
// After a group's last pixel is accepted, its shares are evaluated in turn, and each share is
// loaded into the output register on its final Horner step; no pixel is accepted meanwhile.
// The single Horner unit in each channel lane takes one coefficient per cycle unless stalled.
// While a share waits to be taken, all but the last Horner step of the next share can run.
// Reset clears control state and restores register defaults (r=2, n=4, 512 x 512);
// coefficient stores are not cleared.
// ----------------------------------------------------------------------------
// threshold_image_share_generator
// Threshold (r,n) image share generator over GF(251): three channel lanes
// evaluate group polynomials and a merging output register builds share pixels.
// ----------------------------------------------------------------------------
module threshold_image_share_generator #(
  parameter int MAX_THRESHOLD = tisg_pkg::MAX_THRESHOLD_DEF,
  parameter int MAX_SHARES    = tisg_pkg::MAX_SHARES_DEF,
  parameter int COORD_WIDTH   = tisg_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [tisg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tisg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [tisg_pkg::CHAN_W-1:0]      chan0_i,
  input  wire logic [tisg_pkg::CHAN_W-1:0]      chan1_i,
  input  wire logic [tisg_pkg::CHAN_W-1:0]      chan2_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [tisg_pkg::SHARE_IDX_W-1:0]      share_index_o,
  output logic [COORD_WIDTH-1:0]                out_row_o,
  output logic [COORD_WIDTH-1:0]                out_col_o,
  output logic [tisg_pkg::CHAN_W-1:0]           share0_o,
  output logic [tisg_pkg::CHAN_W-1:0]           share1_o,
  output logic [tisg_pkg::CHAN_W-1:0]           share2_o,
  output logic                                  last_o
);
  import tisg_pkg::*;

  lane_ctl_t             lane_ctl;
  emit_t                 emit;
  logic [COORD_WIDTH-1:0] row, col;
  logic [CHAN_W-1:0]     res0, res1, res2;
  logic                  out_valid_q;
  logic                  out_free;

  logic [SHARE_IDX_W-1:0] index_q;
  logic [COORD_WIDTH-1:0] row_q, col_q;
  logic [CHAN_W-1:0]      sh0_q, sh1_q, sh2_q;
  logic                   last_q;

  assign out_free = !out_valid_q || out_ready_i;

  tisg_ctrl #(
    .MAX_THRESHOLD (MAX_THRESHOLD),
    .MAX_SHARES    (MAX_SHARES),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .lane_ctl_o (lane_ctl),
    .emit_o     (emit),
    .out_row_o  (row),
    .out_col_o  (col)
  );

  tisg_lane #(.MAX_THRESHOLD(MAX_THRESHOLD)) u_lane0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .pix_i  (chan0_i),
    .res_o  (res0)
  );

  tisg_lane #(.MAX_THRESHOLD(MAX_THRESHOLD)) u_lane1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .pix_i  (chan1_i),
    .res_o  (res1)
  );

  tisg_lane #(.MAX_THRESHOLD(MAX_THRESHOLD)) u_lane2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .pix_i  (chan2_i),
    .res_o  (res2)
  );

  // Merge the lane results with the share position into one transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.load) begin
      index_q <= emit.index;
      row_q   <= row;
      col_q   <= col;
      sh0_q   <= res0;
      sh1_q   <= res1;
      sh2_q   <= res2;
      last_q  <= emit.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign share_index_o = index_q;
  assign out_row_o     = row_q;
  assign out_col_o     = col_q;
  assign share0_o      = sh0_q;
  assign share1_o      = sh1_q;
  assign share2_o      = sh2_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

>>> test/threshold_image_share_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// threshold_image_share_generator_tb
// Self-checking bench for the GF(251) image share generator. A scripted
// opening covers clamping, the register extremes and the shadow edge cases.
// Random phases then follow with random register settings and random flow
// control on both channels. Every share pixel is checked against an
// in-bench Horner evaluator that tracks groups and the shadow position.
// ----------------------------------------------------------------------------
module threshold_image_share_generator_tb;
  import tisg_pkg::*;

  localparam int MAX_THR        = MAX_THRESHOLD_DEF;
  localparam int MAX_SHR        = MAX_SHARES_DEF;
  localparam int COORD_W        = COORD_WIDTH_DEF;
  localparam int COORD_SPAN     = 1 << COORD_W;
  localparam int SETTLE_CYCLES  = MAX_THR * (MAX_SHR + 2) + 20;
  localparam int HOLD_CYCLES    = 1500;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 32;
  localparam int PRESSURE_PHASE = 9;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int SCRIPT_LEN     = 38;

  typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_e;

  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [CHAN_W-1:0]     c0;
    logic [CHAN_W-1:0]     c1;
    logic [CHAN_W-1:0]     c2;
    logic                  typed;
    logic [CHAN_W-1:0]     t0;
    logic [CHAN_W-1:0]     t1;
    logic [CHAN_W-1:0]     t2;
  } script_step_t;

  typedef struct packed {
    logic [SHARE_IDX_W-1:0] idx;
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     col;
    logic [CHAN_W-1:0]      s0;
    logic [CHAN_W-1:0]      s1;
    logic [CHAN_W-1:0]      s2;
    logic                   last;
  } share_pixel_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CHAN_W-1:0]      chan0 = '0;
  logic [CHAN_W-1:0]      chan1 = '0;
  logic [CHAN_W-1:0]      chan2 = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SHARE_IDX_W-1:0] share_index;
  logic [COORD_W-1:0]     out_row;
  logic [COORD_W-1:0]     out_col;
  logic [CHAN_W-1:0]      share0;
  logic [CHAN_W-1:0]      share1;
  logic [CHAN_W-1:0]      share2;
  logic                   last;

  // Flow control knobs.
  int   snd_idle_pct = 28;
  int   rcv_idle_pct = 77;
  logic hold_go = 1'b0;
  logic rcv_hold = 1'b0;

  // Register copies and group state of the share evaluator.
  logic [CNT_CFG_W-1:0]  thr_cfg = THRESHOLD_RST;
  logic [CNT_CFG_W-1:0]  shr_cfg = SHARES_RST;
  logic [CFG_DATA_W-1:0] wid_cfg = WIDTH_RST;
  logic [CFG_DATA_W-1:0] hgt_cfg = HEIGHT_RST;
  int                    coef [3][MAX_THR];
  int                    group_fill = 0;
  int                    shadow_row = 0;
  int                    shadow_col = 0;

  share_pixel_t pending_shares [$];
  share_pixel_t next_share;
  script_step_t script [SCRIPT_LEN];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  threshold_image_share_generator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .chan0_i      (chan0),
    .chan1_i      (chan1),
    .chan2_i      (chan2),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .share_index_o(share_index),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .share0_o     (share0),
    .share1_o     (share1),
    .share2_o     (share2),
    .last_o       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Polynomial value of one channel at point x, by Horner's rule mod 251.
  function automatic logic [CHAN_W-1:0] horner_gf251(input int ch, input int r, input int x);
    int acc;
    acc = 0;
    for (int m = r - 1; m >= 0; m--) begin
      acc = (acc * x + coef[ch][m]) % int'(PRIME);
    end
    return CHAN_W'(acc);
  endfunction

  // Stores one pixel as a coefficient and queues the shares of a finished group.
  task automatic gather_pixel(input logic [CHAN_W-1:0] c0, c1, c2);
    int                r;
    int                n;
    int                w;
    int                h;
    int                pos;
    logic [CHAN_W-1:0] px [3];
    share_pixel_t      sp;
    px = '{c0, c1, c2};
    r = (thr_cfg == 0) ? 1 : (thr_cfg > MAX_THR) ? MAX_THR : int'(thr_cfg);
    n = (shr_cfg > MAX_SHR) ? MAX_SHR : int'(shr_cfg);
    w = (wid_cfg > COORD_SPAN) ? COORD_SPAN : int'(wid_cfg);
    h = (hgt_cfg > COORD_SPAN) ? COORD_SPAN : int'(hgt_cfg);
    pos = (group_fill >= MAX_THR) ? MAX_THR - 1 : group_fill;
    for (int ch = 0; ch < 3; ch++) begin
      coef[ch][pos] = (px[ch] > CLAMP_TOP) ? int'(CLAMP_TOP) : int'(px[ch]);
    end
    if (group_fill + 1 < r) begin
      group_fill++;
      return;
    end
    group_fill = 0;
    if (shadow_row < h && shadow_col < w) begin
      for (int t = 0; t < n; t++) begin
        sp.idx  = SHARE_IDX_W'(t);
        sp.row  = COORD_W'(shadow_row);
        sp.col  = COORD_W'(shadow_col);
        sp.s0   = horner_gf251(0, r, t + 1);
        sp.s1   = horner_gf251(1, r, t + 1);
        sp.s2   = horner_gf251(2, r, t + 1);
        sp.last = (t + 1 == n);
        pending_shares = {pending_shares, sp};
      end
    end
    // A column past a lowered width also wraps; the row saturates at the span.
    if (shadow_col + 1 >= w) begin
      shadow_col = 0;
      if (shadow_row < COORD_SPAN) shadow_row++;
    end else begin
      shadow_col++;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one pixel and returns how many shares its transaction queued.
  task automatic push_pixel(input logic [CHAN_W-1:0] c0, c1, c2, output int made);
    int queued;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    chan0    <= c0;
    chan1    <= c1;
    chan2    <= c2;
    do @(posedge clk); while (!in_ready);
    queued = pending_shares.size();
    gather_pixel(c0, c1, c2);
    made = pending_shares.size() - queued;
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD: thr_cfg = data[CNT_CFG_W-1:0];
      REG_SHARES:    shr_cfg = data[CNT_CFG_W-1:0];
      REG_WIDTH:     wid_cfg = data;
      REG_HEIGHT:    hgt_cfg = data;
      default: ;
    endcase
  endtask

  // Waits for every queued share, then for a group that emits nothing to finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_shares.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] pick_chan();
    if ($urandom_range(0, 5) == 0) return CHAN_W'($urandom_range(CLAMP_TOP - 4, 255));
    return CHAN_W'($urandom);
  endfunction

  always @(posedge clk) begin
    if (rcv_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  initial begin
    wait (hold_go);
    rcv_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rcv_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_shares.size() == 0) begin
        flag_mismatch("unexpected share", 16'(share_index), 16'd0);
      end else begin
        next_share = pending_shares.pop_front();
        if (share_index !== next_share.idx) begin
          flag_mismatch("share_index", 16'(share_index), 16'(next_share.idx));
        end
        if (out_row !== next_share.row) begin
          flag_mismatch("out_row", 16'(out_row), 16'(next_share.row));
        end
        if (out_col !== next_share.col) begin
          flag_mismatch("out_col", 16'(out_col), 16'(next_share.col));
        end
        if (share0 !== next_share.s0) begin
          flag_mismatch("share0", 16'(share0), 16'(next_share.s0));
        end
        if (share1 !== next_share.s1) begin
          flag_mismatch("share1", 16'(share1), 16'(next_share.s1));
        end
        if (share2 !== next_share.s2) begin
          flag_mismatch("share2", 16'(share2), 16'(next_share.s2));
        end
        if (last !== next_share.last) begin
          flag_mismatch("last", 16'(last), 16'(next_share.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[threshold_image_share_generator] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    script_step_t          cur;
    int                    made;
    logic [CNT_CFG_W-1:0]  thr;
    logic [CNT_CFG_W-1:0]  shr;
    logic [CFG_DATA_W-1:0] wid;
    logic [CFG_DATA_W-1:0] hgt;

    // Typed values hold where each group's polynomial is plainly constant:
    // zero pixels, a clamped lead pixel over zeros, single-pixel groups, and
    // eight saturated pixels evaluated at x = 1 (8 * 250 mod 251 = 243).
    script = '{
      '{STEP_PIXEL, REG_THRESHOLD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 0, 0, 0, 1, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 251, 250, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 0, 0, 0, 1, 250, 250, 250},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 1, 2, 3, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 4, 5, 6, 0, 0, 0, 0},
      '{STEP_WRITE, REG_THRESHOLD, 1, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_WRITE, REG_SHARES, 8, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 128, 0, 1, 250, 128, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 251, 250, 249, 1, 250, 250, 249},
      '{STEP_WRITE, REG_THRESHOLD, 15, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_WRITE, REG_SHARES, 1, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 255, 0, 255, 1, 243, 0, 243},
      '{STEP_WRITE, REG_THRESHOLD, 0, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_WRITE, REG_SHARES, 0, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 7, 7, 7, 0, 0, 0, 0},
      '{STEP_WRITE, REG_SHARES, 15, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 9, 200, 255, 1, 9, 200, 250},
      '{STEP_WRITE, REG_WIDTH, 0, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 1, 1, 1, 0, 0, 0, 0},
      '{STEP_WRITE, REG_WIDTH, 1, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_WRITE, REG_HEIGHT, 0, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 2, 2, 2, 0, 0, 0, 0},
      '{STEP_WRITE, REG_HEIGHT, 8191, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 3, 4, 5, 1, 3, 4, 5},
      '{STEP_WRITE, REG_WIDTH, 8191, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_WRITE, REG_THRESHOLD, 3, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 10, 20, 30, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 40, 50, 60, 0, 0, 0, 0},
      '{STEP_WRITE, REG_THRESHOLD, 1, 0, 0, 0, 0, 0, 0, 0},
      '{STEP_PIXEL, REG_THRESHOLD, 0, 70, 80, 90, 1, 10, 20, 30}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      cur = script[i];
      if (cur.kind == STEP_WRITE) begin
        settle();
        write_reg(cur.idx, cur.data);
        cfg_we <= 1'b0;
      end else begin
        push_pixel(cur.c0, cur.c1, cur.c2, made);
        if (cur.typed) begin
          for (int k = pending_shares.size() - made; k < pending_shares.size(); k++) begin
            pending_shares[k].s0 = cur.t0;
            pending_shares[k].s1 = cur.t1;
            pending_shares[k].s2 = cur.t2;
          end
        end
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      case (ph / 4)
        0: begin
          snd_idle_pct = 28;
          rcv_idle_pct = 77;
        end
        1: begin
          snd_idle_pct = 77;
          rcv_idle_pct = 28;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase

      case ($urandom_range(0, 9))
        0:       thr = '0;
        1:       thr = CNT_CFG_W'($urandom_range(MAX_THR + 1, 15));
        2:       thr = CNT_CFG_W'(MAX_THR);
        3:       thr = CNT_CFG_W'(1);
        default: thr = CNT_CFG_W'($urandom_range(1, MAX_THR));
      endcase
      case ($urandom_range(0, 11))
        0:       shr = '0;
        1:       shr = CNT_CFG_W'($urandom_range(MAX_SHR + 1, 15));
        2:       shr = CNT_CFG_W'(MAX_SHR);
        3:       shr = CNT_CFG_W'(1);
        default: shr = CNT_CFG_W'($urandom_range(1, MAX_SHR));
      endcase
      case ($urandom_range(0, 7))
        0:       wid = '0;
        1:       wid = CFG_DATA_W'(1);
        2:       wid = CFG_DATA_W'(8191);
        3:       wid = CFG_DATA_W'(COORD_SPAN);
        default: wid = CFG_DATA_W'($urandom_range(2, 12));
      endcase
      // The shadow row never goes back, so heights track it to keep shares coming.
      case ($urandom_range(0, 9))
        0:       hgt = CFG_DATA_W'(8191);
        1:       hgt = '0;
        2:       hgt = CFG_DATA_W'(COORD_SPAN);
        default: hgt = CFG_DATA_W'(shadow_row + $urandom_range(1, 12));
      endcase

      // Every group must produce shares while the output side is held off.
      if (ph == PRESSURE_PHASE) begin
        shr = CNT_CFG_W'(MAX_SHR);
        wid = CFG_DATA_W'(8191);
        hgt = CFG_DATA_W'(8191);
      end

      write_reg(REG_THRESHOLD, {9'($urandom_range(0, 511)), thr});
      write_reg(REG_SHARES, {9'($urandom_range(0, 511)), shr});
      write_reg(REG_WIDTH, wid);
      write_reg(REG_HEIGHT, hgt);
      cfg_we <= 1'b0;

      // The output side stops for a long stretch while pixels keep coming.
      if (ph == PRESSURE_PHASE) hold_go = 1'b1;

      repeat (PHASE_ITEMS) push_pixel(pick_chan(), pick_chan(), pick_chan(), made);
    end

    settle();
    if (mismatch_count == 0) begin
      $display("[threshold_image_share_generator] OK");
    end else begin
      $display("[threshold_image_share_generator] ERROR");
    end
    $finish;
  end

endmodule
